// ===== hdl/bbox_grid_cell_cover_macros.svh =====
// Assertion macros for the grid cell cover block
`ifndef BBOX_GRID_CELL_COVER_MACROS_SVH
`define BBOX_GRID_CELL_COVER_MACROS_SVH

// condition implies consequence in the same cycle
`define BGC_ASSERT_IMP(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the following cycle
`define BGC_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/bgc_pkg.sv =====
package bgc_pkg;

    localparam int MaxCells = 64;
    localparam int CntW     = 7;    // holds 0..MaxCells
    localparam int DivSteps = 33;   // quotient bits of one floor division

    // configuration register indexes
    localparam logic RegCell = 1'b0;
    localparam logic RegTile = 1'b1;

    typedef enum logic [1:0] {
        t_FR_IDLE,
        t_FR_DIV,
        t_FR_PUSH
    } t_fr_state;

    // classified box handed from front to back
    typedef struct packed {
        logic [47:0]        id;
        logic signed [31:0] y0;
        logic signed [31:0] x0;
        logic signed [31:0] orow;
        logic signed [31:0] ocol;
        logic [CntW-1:0]    cols;
        logic [CntW-1:0]    n;
        logic               trunc;
        logic               empty;
    } t_job;

    localparam int JobW = $bits(t_job);

    // result word fields
    typedef struct packed {
        logic               empty_res;
        logic               truncated;
        logic               last;
        logic signed [31:0] owner_col;
        logic signed [31:0] owner_row;
        logic signed [31:0] cell_col;
        logic signed [31:0] cell_row;
        logic [47:0]        out_id;
    } t_res;

endpackage

// ===== hdl/bgc_fdiv.sv =====
// Restoring floor division, one quotient bit per cycle.
// Dividend 33-bit signed, divisor 32-bit positive, quotient 33-bit signed.
module bgc_fdiv import bgc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [32:0] i_num,
    input  logic [31:0]        i_den,
    output logic               o_done,
    output logic signed [32:0] o_quo
);
    // floor(a/d) for a<0 : -(ceil(-a/d)) = -((-a + d - 1) / d)
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_neg;
    logic [32:0] r_q;
    logic [32:0] r_rem;
    logic [31:0] r_den;
    logic [33:0] w_mag;
    logic [33:0] w_trial;
    logic [33:0] w_sub;

    assign w_mag   = i_num[32] ? ({1'b0, (~i_num + 33'd1)} + {2'b0, i_den} - 34'd1)
                               : {1'b0, i_num};
    assign w_trial = {r_rem, r_q[32]};
    assign w_sub   = w_trial - {2'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'(DivSteps);
                r_neg  <= i_num[32];
                r_den  <= i_den;
                r_rem  <= '0;
                r_q    <= w_mag[32:0];
            end else if (r_busy) begin
                if (!w_sub[33]) begin
                    r_rem <= w_sub[32:0];
                    r_q   <= {r_q[31:0], 1'b1};
                end else begin
                    r_rem <= w_trial[32:0];
                    r_q   <= {r_q[31:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_quo = r_neg ? -$signed(r_q) : $signed(r_q);
endmodule

// ===== hdl/bgc_front.sv =====
// Accepts boxes, runs six floor divisions on one shared divider, classifies.
module bgc_front import bgc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [47:0] i_item_id,
    input  logic signed [30:0] i_lat_min,
    input  logic signed [30:0] i_lat_max,
    input  logic signed [31:0] i_lon_min,
    input  logic signed [31:0] i_lon_max,
    input  logic [30:0] i_cell_size,
    input  logic [29:0] i_tile_size,
    output logic        o_push,
    output t_job        o_job,
    input  logic        i_full
);
    t_fr_state r_state, n_state;
    logic [2:0] r_idx, n_idx;
    logic [47:0] r_id;
    logic signed [32:0] r_a [4];   // la0 la1 lo0 lo1
    logic signed [32:0] r_q [6];
    logic [31:0] r_cs, r_ts2;
    logic        w_start;
    logic signed [32:0] w_num;
    logic [31:0] w_den;
    logic        w_done;
    logic signed [32:0] w_quo;

    bgc_fdiv u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start),
        .i_num(w_num), .i_den(w_den), .o_done(w_done), .o_quo(w_quo)
    );

    // divisions: 0 owner row, 1 owner col, 2 y0, 3 y1, 4 x0, 5 x1
    always_comb begin
        case (r_idx)
            3'd0:    begin w_num = r_a[0] + r_a[1]; w_den = r_ts2; end
            3'd1:    begin w_num = r_a[2] + r_a[3]; w_den = r_ts2; end
            3'd2:    begin w_num = r_a[0]; w_den = r_cs; end
            3'd3:    begin w_num = r_a[1]; w_den = r_cs; end
            3'd4:    begin w_num = r_a[2]; w_den = r_cs; end
            default: begin w_num = r_a[3]; w_den = r_cs; end
        endcase
    end

    logic r_go;
    assign w_start = r_go;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        o_ready = 1'b0;
        o_push  = 1'b0;
        case (r_state)
            t_FR_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_state = t_FR_DIV;
                    n_idx   = '0;
                end
            end
            t_FR_DIV: begin
                if (w_done) begin
                    n_idx = r_idx + 3'd1;
                    if (r_idx == 3'd5) n_state = t_FR_PUSH;
                end
            end
            t_FR_PUSH: begin
                if (!i_full) begin
                    o_push  = 1'b1;
                    n_state = t_FR_IDLE;
                end
            end
            default: n_state = t_FR_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= t_FR_IDLE;
            r_idx   <= '0;
            r_go    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_go    <= (r_state == t_FR_IDLE && i_valid)
                    || (r_state == t_FR_DIV && w_done && r_idx != 3'd5);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == t_FR_IDLE && i_valid) begin
            r_id  <= i_item_id;
            r_a[0] <= 33'(i_lat_min);
            r_a[1] <= 33'(i_lat_max);
            r_a[2] <= 33'(i_lon_min);
            r_a[3] <= 33'(i_lon_max);
            r_cs  <= {1'b0, (i_cell_size == '0) ? 31'd1 : i_cell_size};
            r_ts2 <= {1'b0, (i_tile_size == '0) ? 30'd1 : i_tile_size, 1'b0};
        end
        if (r_state == t_FR_DIV && w_done) r_q[r_idx] <= w_quo;
    end

    // classification
    logic signed [33:0] w_dr, w_dc;
    logic w_rbig, w_cbig;
    logic [13:0] w_prod;
    assign w_dr   = 34'(r_q[3]) - 34'(r_q[2]);
    assign w_dc   = 34'(r_q[5]) - 34'(r_q[4]);
    assign w_rbig = w_dr > 34'sd63;
    assign w_cbig = w_dc > 34'sd63;
    assign w_prod = 14'(7'(w_dr) + 7'd1) * 14'(7'(w_dc) + 7'd1);

    always_comb begin
        o_job.id    = r_id;
        o_job.y0    = r_q[2][31:0];
        o_job.x0    = r_q[4][31:0];
        o_job.orow  = r_q[0][31:0];
        o_job.ocol  = r_q[1][31:0];
        o_job.empty = (r_a[0] > r_a[1]) || (r_a[2] > r_a[3]);
        o_job.cols  = w_cbig ? 7'(MaxCells) : 7'(w_dc) + 7'd1;
        o_job.trunc = !o_job.empty && (w_rbig || w_cbig || w_prod > 14'(MaxCells));
        o_job.n     = o_job.empty ? 7'd1 : (o_job.trunc ? 7'(MaxCells) : 7'(w_prod));
    end
endmodule

// ===== hdl/bgc_fifo.sv =====
// Two-entry job queue between classifier and emitter.
module bgc_fifo import bgc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_nempty,
    output t_job o_data
);
    t_job r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full   = r_cnt == 2'd2;
    assign o_nempty = r_cnt != 2'd0;
    assign o_data   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end
endmodule

// ===== hdl/bgc_back.sv =====
// Walks the cells of one job row-major into a one-word output register.
module bgc_back import bgc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_nempty,
    input  t_job        i_job,
    output logic        o_pop,
    output logic        o_tvalid,
    input  logic        i_tready,
    output t_res        o_res
);
    `include "bbox_grid_cell_cover_macros.svh"

    logic [CntW-1:0] r_k, r_r, r_c;
    logic            w_load;
    logic            w_last;

    assign w_load = i_nempty && (!o_tvalid || i_tready);
    assign w_last = (r_k + 7'd1) == i_job.n;
    assign o_pop  = w_load && w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_tvalid <= 1'b0;
            r_k <= '0;
            r_r <= '0;
            r_c <= '0;
        end else begin
            if (w_load) begin
                o_tvalid <= 1'b1;
                if (w_last) begin
                    r_k <= '0; r_r <= '0; r_c <= '0;
                end else begin
                    r_k <= r_k + 7'd1;
                    if (r_c + 7'd1 == i_job.cols) begin
                        r_c <= '0;
                        r_r <= r_r + 7'd1;
                    end else begin
                        r_c <= r_c + 7'd1;
                    end
                end
            end else if (i_tready) begin
                o_tvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            o_res.out_id    <= i_job.id;
            o_res.cell_row  <= i_job.empty ? '0 : i_job.y0 + 32'(r_r);
            o_res.cell_col  <= i_job.empty ? '0 : i_job.x0 + 32'(r_c);
            o_res.owner_row <= i_job.orow;
            o_res.owner_col <= i_job.ocol;
            o_res.last      <= w_last;
            o_res.truncated <= w_last && i_job.trunc;
            o_res.empty_res <= i_job.empty;
        end
    end

    `BGC_ASSERT_IMP(a_pop_last, i_clk, i_rst_n, o_pop, w_load && w_last, "pop without last")
    `BGC_ASSERT_NEXT(a_pop_out_last, i_clk, i_rst_n, o_pop, o_tvalid && o_res.last, "last lost")
    `BGC_ASSERT_IMP(a_k_bound, i_clk, i_rst_n, i_nempty, r_k < i_job.n, "cell index past count")
endmodule

// ===== hdl/bbox_grid_cell_cover.sv =====
// Grid cell cover of one bounding box. A box word is taken, then six floor
// divisions (owner center on both axes, cell bounds on both axes) run on one
// shared bit-serial divider (start, 33 quotient steps, result capture each);
// a box word is taken only once the previous job is queued. The job goes
// through a two-entry queue to the emitter, which puts out one cell word per
// cycle while the receiver is ready (up to 64, or one empty word) as the next
// box is divided. Sizes of zero act as one. Configuration writes land at once.
module bbox_grid_cell_cover import bgc_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // item_id[47:0] lat_min[78:48] lat_max[109:79] lon_min[141:110] lon_max[173:142]
    input  logic [175:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_id[47:0] cell_row[79:48] cell_col[111:80] owner_row[143:112] owner_col[175:144]
    output logic [175:0] m_axis_tdata,
    // truncated[0] empty_res[1]
    output logic [1:0]   m_axis_tuser,
    output logic         m_axis_tlast,
    input  logic         i_cfg_we,
    input  logic         i_cfg_idx,
    input  logic [30:0]  i_cfg_data
);
    logic [30:0] r_cell_size;
    logic [29:0] r_tile_size;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_size <= 31'd100000;
            r_tile_size <= 30'd500000;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                RegCell: r_cell_size <= i_cfg_data;
                RegTile: r_tile_size <= i_cfg_data[29:0];
                default: ;
            endcase
        end
    end

    t_job w_job_in, w_job_out;
    logic w_push, w_full, w_pop, w_nempty;
    t_res w_res;

    bgc_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_item_id(s_axis_tdata[47:0]),
        .i_lat_min(s_axis_tdata[78:48]), .i_lat_max(s_axis_tdata[109:79]),
        .i_lon_min(s_axis_tdata[141:110]), .i_lon_max(s_axis_tdata[173:142]),
        .i_cell_size(r_cell_size), .i_tile_size(r_tile_size),
        .o_push(w_push), .o_job(w_job_in), .i_full(w_full)
    );

    bgc_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(w_push), .i_data(w_job_in), .o_full(w_full),
        .i_pop(w_pop), .o_nempty(w_nempty), .o_data(w_job_out)
    );

    bgc_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_nempty(w_nempty), .i_job(w_job_out), .o_pop(w_pop),
        .o_tvalid(m_axis_tvalid), .i_tready(m_axis_tready), .o_res(w_res)
    );

    assign m_axis_tdata = {w_res.owner_col, w_res.owner_row, w_res.cell_col,
                           w_res.cell_row, w_res.out_id};
    assign m_axis_tuser = {w_res.empty_res, w_res.truncated};
    assign m_axis_tlast = w_res.last;
endmodule

// ===== test/bbox_grid_cell_cover_tb.sv =====
`timescale 1ns / 1ps

module bbox_grid_cell_cover_tb import bgc_pkg::*;;

    localparam int   NumRand = 200;

    // one cover word as seen on the master side
    typedef struct packed {
        logic [47:0]        id;
        logic signed [31:0] crow;
        logic signed [31:0] ccol;
        logic signed [31:0] orow;
        logic signed [31:0] ocol;
        logic               lst;
        logic               trunc;
        logic               empty;
    } t_cover;

    // directed row: box plus, where obvious, the first word expected
    typedef struct {
        logic [47:0]        id;
        logic signed [30:0] la0;
        logic signed [30:0] la1;
        logic signed [31:0] lo0;
        logic signed [31:0] lo1;
        bit                 typed;
        t_cover             first;
    } t_box_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // item_id, lat_min, lat_max, lon_min, lon_max (low bits first)
    logic [175:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // out_id, cell_row, cell_col, owner_row, owner_col (low bits first)
    logic [175:0] m_axis_tdata;
    // truncated, empty_res (low bit first)
    logic [1:0]   m_axis_tuser;
    logic         m_axis_tlast;
    logic         i_cfg_we = 1'b0;
    logic         i_cfg_idx = RegCell;
    logic [30:0]  i_cfg_data = '0;

    bbox_grid_cell_cover i_dut (.*);

    always #4 i_clk = ~i_clk;

    // predictor's copy of the registers
    longint cell_sz = 100000;
    longint tile_sz = 500000;

    t_cover cover_q[$];
    int     n_err = 0;
    int     n_words = 0;
    int     n_trunc = 0;
    int     n_empty = 0;
    int     last_run = 0;     // words queued for the latest box
    int     rx_idle = 0;      // remaining receiver idle cycles of a burst
    bit     calm = 1'b0;      // no idling in the closing stretch
    bit     hold_req = 1'b0;  // long receiver hold-off request
    bit     hold_rx = 1'b0;   // receiver held off

    function automatic longint floor_quot(longint a, longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0) q -= 1;
        return q;
    endfunction

    // works out every cover word of one box and queues it
    function automatic void predict_cover(logic [47:0] id, longint la0, longint la1,
                                          longint lo0, longint lo1);
        longint cs, ts2, orow, ocol, y0, y1, x0, x1, rows, cols, total, n;
        t_cover w;
        cs   = (cell_sz == 0) ? 1 : cell_sz;
        ts2  = 2 * ((tile_sz == 0) ? 1 : tile_sz);
        orow = floor_quot(la0 + la1, ts2);
        ocol = floor_quot(lo0 + lo1, ts2);
        w.id = id; w.orow = orow[31:0]; w.ocol = ocol[31:0];
        if (la0 > la1 || lo0 > lo1) begin
            w.crow = 0; w.ccol = 0; w.lst = 1; w.trunc = 0; w.empty = 1;
            cover_q.insert(cover_q.size(), w);
            last_run = 1;
            return;
        end
        y0 = floor_quot(la0, cs); y1 = floor_quot(la1, cs);
        x0 = floor_quot(lo0, cs); x1 = floor_quot(lo1, cs);
        rows = y1 - y0 + 1; cols = x1 - x0 + 1;
        total = (rows > MaxCells || cols > MaxCells) ? MaxCells + 1 : rows * cols;
        n = (total > MaxCells) ? MaxCells : total;
        for (longint k = 0; k < n; k++) begin
            w.crow  = 32'(y0 + k / cols);
            w.ccol  = 32'(x0 + k % cols);
            w.lst   = (k + 1 == n);
            w.trunc = w.lst && (total > MaxCells);
            w.empty = 0;
            cover_q.insert(cover_q.size(), w);
        end
        last_run = int'(n);
    endfunction

    task automatic cfg_write(logic idx, longint val);
        @(negedge i_clk);
        i_cfg_we = 1'b1; i_cfg_idx = idx; i_cfg_data = val[30:0];
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == RegCell) cell_sz = val[30:0];
        else tile_sz = val[29:0];
    endtask

    // sends one box word; idles first in random bursts
    task automatic send_box(logic [47:0] id, logic signed [30:0] la0,
                            logic signed [30:0] la1, logic signed [31:0] lo0,
                            logic signed [31:0] lo1);
        if (!calm && $urandom_range(3) == 0) repeat ($urandom_range(1, 6)) @(negedge i_clk);
        s_axis_tdata  = {2'b00, lo1, lo0, la1, la0, id};
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_cover(id, la0, la1, lo0, lo1);
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    // waits for every expected word, then for the divider's worth of quiet
    task automatic drain();
        int guard;
        guard = 0;
        while (cover_q.size() != 0 && guard < 200000) begin
            @(negedge i_clk); guard++;
        end
        repeat (300) @(negedge i_clk);
    endtask

    // receiver: random idle bursts, one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_rx) m_axis_tready <= 1'b0;
        else if (calm) m_axis_tready <= 1'b1;
        else if (rx_idle > 0) begin
            m_axis_tready <= 1'b0;
            rx_idle <= rx_idle - 1;
        end else if ($urandom_range(4) == 0) begin
            m_axis_tready <= 1'b0;
            rx_idle <= int'($urandom_range(0, 5));
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_cover g;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_words++;
            if (cover_q.size() == 0) begin
                $error("unexpected cover word");
                n_err++;
            end else begin
                g = cover_q[0];
                cover_q.delete(0);
                if (m_axis_tdata[47:0] !== g.id) begin
                    $error("out_id exp %h got %h", g.id, m_axis_tdata[47:0]); n_err++;
                end
                if (m_axis_tdata[79:48] !== g.crow) begin
                    $error("cell_row exp %0d got %0d", g.crow,
                           $signed(m_axis_tdata[79:48])); n_err++;
                end
                if (m_axis_tdata[111:80] !== g.ccol) begin
                    $error("cell_col exp %0d got %0d", g.ccol,
                           $signed(m_axis_tdata[111:80])); n_err++;
                end
                if (m_axis_tdata[143:112] !== g.orow) begin
                    $error("owner_row exp %0d got %0d", g.orow,
                           $signed(m_axis_tdata[143:112])); n_err++;
                end
                if (m_axis_tdata[175:144] !== g.ocol) begin
                    $error("owner_col exp %0d got %0d", g.ocol,
                           $signed(m_axis_tdata[175:144])); n_err++;
                end
                if (m_axis_tlast !== g.lst) begin
                    $error("last exp %0b got %0b", g.lst, m_axis_tlast); n_err++;
                end
                if (m_axis_tuser[0] !== g.trunc) begin
                    $error("truncated exp %0b got %0b", g.trunc, m_axis_tuser[0]); n_err++;
                end
                if (m_axis_tuser[1] !== g.empty) begin
                    $error("empty_res exp %0b got %0b", g.empty, m_axis_tuser[1]); n_err++;
                end
                if (g.trunc) n_trunc++;
                if (g.empty) n_empty++;
            end
        end
    end

    initial begin
        #40_000_000;
        $display("simulation failed");
        $finish;
    end

    // random box: mostly a few cells, some wide, some swapped, some full range
    task automatic rand_box(longint cs);
        longint la0, lo0, dla, dlo, t;
        int kind;
        logic signed [30:0] a0, a1;
        logic signed [31:0] b0, b1;
        kind = $urandom_range(19);
        la0 = longint'($urandom_range(1800000000)) - 900000000;
        lo0 = longint'($urandom_range(32'd3600000000)) - 1800000000;
        if (kind < 13) begin
            dla = $urandom_range(3) * cs + $urandom_range(32'(cs));
            dlo = $urandom_range(4) * cs + $urandom_range(32'(cs));
        end else if (kind < 16) begin
            dla = $urandom_range(12) * cs; dlo = $urandom_range(12) * cs;
        end else begin
            dla = $urandom_range(1800000000); dlo = $urandom_range(32'd3600000000);
        end
        t = la0 + dla; if (t > 900000000) t = 900000000;
        a0 = la0[30:0]; a1 = t[30:0];
        t = lo0 + dlo; if (t > 1800000000) t = 1800000000;
        b0 = lo0[31:0]; b1 = t[31:0];
        if (kind == 19) begin
            if ($urandom_range(1)) {a0, a1} = {a1, a0 - 31'sd1};
            else {b0, b1} = {b1, b0 - 32'sd1};
        end
        send_box(48'({$urandom, $urandom}), a0, a1, b0, b1);
    endtask

    initial begin
        t_box_row rows_tab[$];
        t_box_row r;
        t_cover   g;
        longint   cs_list[5];
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed boxes at reset sizes; typed words where plain to read
        r = '{48'h0, 31'sd0, 31'sd0, 32'sd0, 32'sd0, 1,
              '{48'h0, 0, 0, 0, 0, 1, 0, 0}};
        rows_tab.insert(rows_tab.size(), r);
        r = '{48'hFFFF_FFFF_FFFF, 31'sd10, 31'sd5, 32'sd0, 32'sd0, 1,
              '{48'hFFFF_FFFF_FFFF, 0, 0, 0, 0, 1, 0, 1}};
        rows_tab.insert(rows_tab.size(), r);
        r = '{48'h1, -31'sd900000000, 31'sd900000000,
              -32'sd1800000000, 32'sd1800000000, 1,
              '{48'h1, -9000, -18000, 0, 0, 0, 0, 0}};
        rows_tab.insert(rows_tab.size(), r);
        r = '{48'h2, -31'sd1, -31'sd1, -32'sd1, -32'sd1, 1,
              '{48'h2, -1, -1, -1, -1, 1, 0, 0}};
        rows_tab.insert(rows_tab.size(), r);
        r = '{48'h3, 31'sd0, 31'sd0, 32'sd5, 32'sd1, 1,
              '{48'h3, 0, 0, 0, 0, 1, 0, 1}};
        rows_tab.insert(rows_tab.size(), r);
        r = '{48'hA5A5_5A5A_A5A5, 31'sd900000000, 31'sd900000000,
              32'sd1800000000, 32'sd1800000000, 0, '{default: '0}};
        rows_tab.insert(rows_tab.size(), r);
        r = '{48'h5A5A_A5A5_5A5A, -31'sd900000000, -31'sd900000000,
              -32'sd1800000000, -32'sd1800000000, 0, '{default: '0}};
        rows_tab.insert(rows_tab.size(), r);
        r = '{48'h4, -31'sd150000, 31'sd250000, -32'sd99999, 32'sd100000, 0,
              '{default: '0}};
        rows_tab.insert(rows_tab.size(), r);
        r = '{48'h5, 31'sd0, 31'sd6399999, 32'sd0, 32'sd99999, 0, '{default: '0}};
        rows_tab.insert(rows_tab.size(), r);
        r = '{48'h6, 31'sd0, 31'sd799999, 32'sd0, 32'sd799999, 0, '{default: '0}};
        rows_tab.insert(rows_tab.size(), r);
        r = '{48'h7, 31'sd0, 31'sd799999, 32'sd0, 32'sd899999, 0, '{default: '0}};
        rows_tab.insert(rows_tab.size(), r);

        foreach (rows_tab[i]) begin
            send_box(rows_tab[i].id, rows_tab[i].la0, rows_tab[i].la1,
                     rows_tab[i].lo0, rows_tab[i].lo1);
            if (rows_tab[i].typed) begin
                // this box's words are still all at the tail of the queue
                g = cover_q[cover_q.size() - last_run];
                if (g != rows_tab[i].first) begin
                    $error("directed row %0d: predicted first word differs", i);
                    n_err++;
                end
            end
        end
        drain();

        // extreme and zero sizes, then several random phases
        cfg_write(RegCell, 0); cfg_write(RegTile, 0);
        send_box(48'h10, -31'sd3, 31'sd3, 32'sd0, 32'sd4);
        send_box(48'h11, 31'sd7, 31'sd7, -32'sd9, -32'sd9);
        drain();
        cfg_write(RegCell, 1800000000); cfg_write(RegTile, 900000000);
        send_box(48'h12, -31'sd900000000, 31'sd900000000,
                 -32'sd1800000000, 32'sd1800000000);
        send_box(48'h13, -31'sd1, 31'sd0, -32'sd1, 32'sd0);
        drain();

        cs_list = '{100000, 1, 7, 30000000, 1800000000};
        for (int ph = 0; ph < 5; ph++) begin
            cfg_write(RegCell, cs_list[ph]);
            cfg_write(RegTile, (ph == 1) ? 1 : $urandom_range(1, 900000000));
            for (int k = 0; k < NumRand / 5; k++) begin
                if (ph == 0 && k == 10) hold_req = 1'b1;
                if (ph == 4 && k == NumRand / 10) calm = 1'b1;
                rand_box((ph == 1 || ph == 2) ? 3 : cs_list[ph]);
            end
            drain();
        end

        $display("covered %0d words, %0d truncated runs, %0d empty boxes",
                 n_words, n_trunc, n_empty);
        if (n_err == 0 && cover_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // long receiver hold-off, counted here while the sender keeps offering
    initial begin
        wait (hold_req);
        hold_rx = 1'b1;
        repeat (900) @(negedge i_clk);
        hold_rx = 1'b0;
    end

endmodule
